FILE: rtl/frdr_pkg.sv
// ----------------------------------------------------------------------------
// frdr_pkg
// Shared constants and types for the dielectric Fresnel reflectance pipeline.
// ----------------------------------------------------------------------------
package frdr_pkg;

   localparam int IOR_FRAC_BITS = 12;
   localparam int IDX_W         = 16;
   localparam int COS_W         = 16;
   localparam int REFL_W        = 16;
   localparam int CSR_IDX_W     = 2;

   localparam int NUM_W         = 62;
   localparam int DEN_W         = 32;
   localparam int TDIV_STAGES   = 31;
   localparam int RAD_W         = 31;
   localparam int ROOT_W        = 16;
   localparam int SQRT_STAGES   = 16;
   localparam int PROD_W        = 32;
   localparam int SUM_W         = 33;
   localparam int RDIV_REM_W    = 49;
   localparam int RDIV_STAGES   = 17;
   localparam int SQ_W          = 34;

   localparam logic [IDX_W-1:0]     NI_RESET  = IDX_W'(1 << IOR_FRAC_BITS);
   localparam logic [IDX_W-1:0]     NT_RESET  = IDX_W'(3 << (IOR_FRAC_BITS - 1));
   localparam logic [REFL_W-1:0]    REFL_ONE  = 16'h8000;
   localparam logic [RDIV_STAGES-1:0] RATIO_ONE = 17'h10000;

   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_INCIDENT    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_TRANSMITTED = 2'd1;

   typedef struct packed {
      logic             tir;
      logic [COS_W-1:0] c;
      logic [IDX_W-1:0] ni;
      logic [IDX_W-1:0] nt;
   } item_type;

endpackage

FILE: rtl/frdr_front.sv
// ----------------------------------------------------------------------------
// frdr_front
// Side select, squares, total internal reflection test and divide operands.
// ----------------------------------------------------------------------------
module frdr_front import frdr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic [COS_W-1:0] in_cos,
   input  logic [IDX_W-1:0] index_incident,
   input  logic [IDX_W-1:0] index_transmitted,
   output logic             out_valid,
   output item_type         out_item,
   output logic [NUM_W-1:0] out_num,
   output logic [DEN_W-1:0] out_den
);

   logic             entering;
   item_type         a_item_in;
   logic             a_valid_ff;
   item_type         a_item_ff;

   logic [31:0]      c2;
   logic             b_valid_ff;
   item_type         b_item_ff;
   logic [RAD_W-1:0] b_s2_ff;
   logic [31:0]      b_ni2_ff;
   logic [31:0]      b_nt2_ff;

   logic [62:0]      lhs_prod;
   logic             c_valid_ff;
   item_type         c_item_ff;
   logic [NUM_W-1:0] c_lhs_ff;
   logic [NUM_W-1:0] c_rhs_ff;
   logic [31:0]      c_nt2_ff;

   item_type         d_item_in;
   logic             d_valid_ff;
   item_type         d_item_ff;
   logic [NUM_W-1:0] d_num_ff;
   logic [DEN_W-1:0] d_den_ff;

   always_comb begin
      entering      = (in_cos != '0) && !in_cos[COS_W-1];
      a_item_in.tir = 1'b0;
      if (entering) begin
         a_item_in.c  = in_cos;
         a_item_in.ni = index_incident;
         a_item_in.nt = index_transmitted;
      end else begin
         a_item_in.c  = COS_W'(17'h10000 - {1'b0, in_cos});
         a_item_in.ni = index_transmitted;
         a_item_in.nt = index_incident;
      end
   end

   assign c2       = 32'(a_item_ff.c) * 32'(a_item_ff.c);
   assign lhs_prod = 63'(b_ni2_ff) * 63'(b_s2_ff);

   always_comb begin
      d_item_in     = c_item_ff;
      d_item_in.tir = (c_lhs_ff >= c_rhs_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_item_ff <= a_item_in;
         b_item_ff <= a_item_ff;
         b_s2_ff   <= RAD_W'(32'h4000_0000 - c2);
         b_ni2_ff  <= 32'(a_item_ff.ni) * 32'(a_item_ff.ni);
         b_nt2_ff  <= 32'(a_item_ff.nt) * 32'(a_item_ff.nt);
         c_item_ff <= b_item_ff;
         c_lhs_ff  <= lhs_prod[NUM_W-1:0];
         c_rhs_ff  <= {b_nt2_ff, 30'b0};
         c_nt2_ff  <= b_nt2_ff;
         d_item_ff <= d_item_in;
         d_num_ff  <= d_item_in.tir ? '0 : (c_rhs_ff - c_lhs_ff);
         d_den_ff  <= c_nt2_ff;
      end
   end

   assign out_valid = d_valid_ff;
   assign out_item  = d_item_ff;
   assign out_num   = d_num_ff;
   assign out_den   = d_den_ff;

endmodule

FILE: rtl/frdr_tdiv.sv
// ----------------------------------------------------------------------------
// frdr_tdiv
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module frdr_tdiv import frdr_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_valid,
   input  item_type               in_item,
   input  logic [NUM_W-1:0]       in_num,
   input  logic [DEN_W-1:0]       in_den,
   output logic                   out_valid,
   output item_type               out_item,
   output logic [TDIV_STAGES-1:0] out_quo
);

   logic                   valid_ff [TDIV_STAGES];
   item_type               item_ff  [TDIV_STAGES];
   logic [NUM_W-1:0]       rem_ff   [TDIV_STAGES];
   logic [DEN_W-1:0]       den_ff   [TDIV_STAGES];
   logic [TDIV_STAGES-1:0] quo_ff   [TDIV_STAGES];

   for (genvar k = 0; k < TDIV_STAGES; k++) begin : g_stage
      localparam int BIT = TDIV_STAGES - 1 - k;
      logic                   src_valid;
      item_type               src_item;
      logic [NUM_W-1:0]       src_rem;
      logic [DEN_W-1:0]       src_den;
      logic [TDIV_STAGES-1:0] src_quo;
      logic [NUM_W-1:0]       trial;
      logic [NUM_W-1:0]       rem_in;
      logic [TDIV_STAGES-1:0] quo_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_item  = in_item;
         assign src_rem   = in_num;
         assign src_den   = in_den;
         assign src_quo   = '0;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_item  = item_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_quo   = quo_ff[k-1];
      end

      assign trial = NUM_W'(src_den) << BIT;

      always_comb begin
         rem_in = src_rem;
         quo_in = src_quo;
         if (src_rem >= trial) begin
            rem_in      = src_rem - trial;
            quo_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[k] <= src_item;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= src_den;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   assign out_valid = valid_ff[TDIV_STAGES-1];
   assign out_item  = item_ff[TDIV_STAGES-1];
   assign out_quo   = quo_ff[TDIV_STAGES-1];

endmodule

FILE: rtl/frdr_sqrt.sv
// ----------------------------------------------------------------------------
// frdr_sqrt
// Pipelined integer square root, one root bit per stage.
// ----------------------------------------------------------------------------
module frdr_sqrt import frdr_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  item_type          in_item,
   input  logic [RAD_W-1:0]  in_rad,
   output logic              out_valid,
   output item_type          out_item,
   output logic [ROOT_W-1:0] out_root
);

   logic             valid_ff [SQRT_STAGES];
   item_type         item_ff  [SQRT_STAGES];
   logic [RAD_W-1:0] rad_ff   [SQRT_STAGES];
   logic [31:0]      res_ff   [SQRT_STAGES];

   for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
      localparam logic [31:0] ONE_BIT = 32'(1) << (30 - 2 * k);
      logic             src_valid;
      item_type         src_item;
      logic [RAD_W-1:0] src_rad;
      logic [31:0]      src_res;
      logic [31:0]      trial;
      logic [RAD_W-1:0] rad_in;
      logic [31:0]      res_in;

      if (k == 0) begin : g_first
         assign src_valid = in_valid;
         assign src_item  = in_item;
         assign src_rad   = in_rad;
         assign src_res   = '0;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_item  = item_ff[k-1];
         assign src_rad   = rad_ff[k-1];
         assign src_res   = res_ff[k-1];
      end

      assign trial = src_res + ONE_BIT;

      always_comb begin
         rad_in = src_rad;
         res_in = src_res >> 1;
         if ({1'b0, src_rad} >= trial) begin
            rad_in = src_rad - trial[RAD_W-1:0];
            res_in = (src_res >> 1) + ONE_BIT;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            item_ff[k] <= src_item;
            rad_ff[k]  <= rad_in;
            res_ff[k]  <= res_in;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_item  = item_ff[SQRT_STAGES-1];
   assign out_root  = res_ff[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

FILE: rtl/frdr_ratio.sv
// ----------------------------------------------------------------------------
// frdr_ratio
// Amplitude ratio |x-y|/(x+y) in Q.16 by pipelined division, then squared.
// ----------------------------------------------------------------------------
module frdr_ratio import frdr_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             en,
   input  logic             in_valid,
   input  logic             in_tag,
   input  logic [15:0]      in_xa,
   input  logic [15:0]      in_xb,
   input  logic [15:0]      in_ya,
   input  logic [15:0]      in_yb,
   output logic             out_valid,
   output logic             out_tag,
   output logic [SQ_W-1:0]  out_sq
);

   logic              m_valid_ff;
   logic              m_tag_ff;
   logic [PROD_W-1:0] m_x_ff;
   logic [PROD_W-1:0] m_y_ff;

   logic              s_valid_ff;
   logic              s_tag_ff;
   logic              s_zero_ff;
   logic [PROD_W-1:0] s_diff_ff;
   logic [SUM_W-1:0]  s_sum_ff;

   logic                   valid_ff [RDIV_STAGES];
   logic                   tag_ff   [RDIV_STAGES];
   logic                   zero_ff  [RDIV_STAGES];
   logic [RDIV_REM_W-1:0]  rem_ff   [RDIV_STAGES];
   logic [SUM_W-1:0]       den_ff   [RDIV_STAGES];
   logic [RDIV_STAGES-1:0] quo_ff   [RDIV_STAGES];

   logic                   q_sel;
   logic [RDIV_STAGES-1:0] q_in;
   logic                   o_valid_ff;
   logic                   o_tag_ff;
   logic [SQ_W-1:0]        o_sq_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else if (en) begin
         m_valid_ff <= in_valid;
         s_valid_ff <= m_valid_ff;
         o_valid_ff <= valid_ff[RDIV_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         m_tag_ff  <= in_tag;
         m_x_ff    <= PROD_W'(in_xa) * PROD_W'(in_xb);
         m_y_ff    <= PROD_W'(in_ya) * PROD_W'(in_yb);
         s_tag_ff  <= m_tag_ff;
         s_diff_ff <= (m_x_ff > m_y_ff) ? (m_x_ff - m_y_ff) : (m_y_ff - m_x_ff);
         s_sum_ff  <= SUM_W'(m_x_ff) + SUM_W'(m_y_ff);
         s_zero_ff <= (m_x_ff == '0) && (m_y_ff == '0);
         o_tag_ff  <= tag_ff[RDIV_STAGES-1];
         o_sq_ff   <= SQ_W'(q_in) * SQ_W'(q_in);
      end
   end

   for (genvar k = 0; k < RDIV_STAGES; k++) begin : g_stage
      localparam int BIT = RDIV_STAGES - 1 - k;
      logic                   src_valid;
      logic                   src_tag;
      logic                   src_zero;
      logic [RDIV_REM_W-1:0]  src_rem;
      logic [SUM_W-1:0]       src_den;
      logic [RDIV_STAGES-1:0] src_quo;
      logic [RDIV_REM_W-1:0]  trial;
      logic [RDIV_REM_W-1:0]  rem_in;
      logic [RDIV_STAGES-1:0] quo_in;

      if (k == 0) begin : g_first
         assign src_valid = s_valid_ff;
         assign src_tag   = s_tag_ff;
         assign src_zero  = s_zero_ff;
         assign src_rem   = {1'b0, s_diff_ff, 16'b0};
         assign src_den   = s_sum_ff;
         assign src_quo   = '0;
      end else begin : g_next
         assign src_valid = valid_ff[k-1];
         assign src_tag   = tag_ff[k-1];
         assign src_zero  = zero_ff[k-1];
         assign src_rem   = rem_ff[k-1];
         assign src_den   = den_ff[k-1];
         assign src_quo   = quo_ff[k-1];
      end

      assign trial = RDIV_REM_W'(src_den) << BIT;

      always_comb begin
         rem_in = src_rem;
         quo_in = src_quo;
         if (src_rem >= trial) begin
            rem_in      = src_rem - trial;
            quo_in[BIT] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            tag_ff[k]  <= src_tag;
            zero_ff[k] <= src_zero;
            rem_ff[k]  <= rem_in;
            den_ff[k]  <= src_den;
            quo_ff[k]  <= quo_in;
         end
      end
   end

   assign q_sel = zero_ff[RDIV_STAGES-1];
   assign q_in  = q_sel ? RATIO_ONE : quo_ff[RDIV_STAGES-1];

   assign out_valid = o_valid_ff;
   assign out_tag   = o_tag_ff;
   assign out_sq    = o_sq_ff;

endmodule

FILE: rtl/fresnel_dielectric_reflectance_top.sv
// Item path: front end, divider, square root, ratio, output register, rsp_.
// Throughput: one item per cycle when not stalled; the divider, square
// root and ratio dividers are fully pipelined at one quotient or root bit
// per stage. The whole pipeline holds while a result waits under rsp_stall.
// Reset: synchronous, active high; clears all valid bits and sets the
// indices to 1.0 (incident) and 1.5 (transmitted).
// ----------------------------------------------------------------------------
// fresnel_dielectric_reflectance_top
// Unpolarized Fresnel reflectance of a dielectric interface, fixed point.
// ----------------------------------------------------------------------------
module fresnel_dielectric_reflectance_top import frdr_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [COS_W-1:0] req_cos_incidence,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [REFL_W-1:0]       rsp_reflectance,
   output logic                    rsp_total_internal,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [IDX_W-1:0]        csr_data
);

   logic [IDX_W-1:0]       ni_ff;
   logic [IDX_W-1:0]       nt_ff;
   logic                   en;

   logic                   f_valid;
   item_type               f_item;
   logic [NUM_W-1:0]       f_num;
   logic [DEN_W-1:0]       f_den;

   logic                   d_valid;
   item_type               d_item;
   logic [TDIV_STAGES-1:0] d_quo;

   logic                   q_valid;
   item_type               q_item;
   logic [ROOT_W-1:0]      q_root;

   logic                   l_valid;
   logic                   l_tag;
   logic [SQ_W-1:0]        l_sq;
   logic [SQ_W-1:0]        r_sq;

   logic [SQ_W-1:0]        sum;
   logic [REFL_W-1:0]      refl;
   logic [REFL_W-1:0]      refl_in;
   logic                   out_valid_ff;
   logic [REFL_W-1:0]      out_refl_ff;
   logic                   out_tir_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ni_ff <= NI_RESET;
         nt_ff <= NT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_INDEX_INCIDENT:    ni_ff <= csr_data;
            CSR_INDEX_TRANSMITTED: nt_ff <= csr_data;
            default: ;
         endcase
      end
   end

   assign en        = !out_valid_ff || !rsp_stall;
   assign req_stall = !en;

   frdr_front u_front (
      .clock             (clock),
      .reset             (reset),
      .en                (en),
      .in_valid          (req_valid),
      .in_cos            ($unsigned(req_cos_incidence)),
      .index_incident    (ni_ff),
      .index_transmitted (nt_ff),
      .out_valid         (f_valid),
      .out_item          (f_item),
      .out_num           (f_num),
      .out_den           (f_den)
   );

   frdr_tdiv u_tdiv (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (f_valid),
      .in_item   (f_item),
      .in_num    (f_num),
      .in_den    (f_den),
      .out_valid (d_valid),
      .out_item  (d_item),
      .out_quo   (d_quo)
   );

   frdr_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (d_valid),
      .in_item   (d_item),
      .in_rad    (d_quo),
      .out_valid (q_valid),
      .out_item  (q_item),
      .out_root  (q_root)
   );

   frdr_ratio u_ratio_l (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q_valid),
      .in_tag    (q_item.tir),
      .in_xa     (q_item.nt),
      .in_xb     (q_item.c),
      .in_ya     (q_item.ni),
      .in_yb     (q_root),
      .out_valid (l_valid),
      .out_tag   (l_tag),
      .out_sq    (l_sq)
   );

   frdr_ratio u_ratio_r (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (q_valid),
      .in_tag    (q_item.tir),
      .in_xa     (q_item.ni),
      .in_xb     (q_item.c),
      .in_ya     (q_item.nt),
      .in_yb     (q_root),
      .out_valid (),
      .out_tag   (),
      .out_sq    (r_sq)
   );

   assign sum  = l_sq + r_sq;
   assign refl = sum[SQ_W-1:18];

   always_comb begin
      if (l_tag || (refl > REFL_ONE)) begin
         refl_in = REFL_ONE;
      end else begin
         refl_in = refl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= l_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_refl_ff <= refl_in;
         out_tir_ff  <= l_tag;
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_reflectance    = out_refl_ff;
   assign rsp_total_internal = out_tir_ff;

endmodule
